>>> hdl/pltl_pkg.sv
// Shared types, codes and widths for the piecewise-linear table lookup block.
package pltl_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NP_WIDTH    = 11;
    localparam int IDX_WIDTH   = 10;
    localparam int ALU_WIDTH   = VALUE_WIDTH + 2;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_FORWARD = 2'd1;
    localparam logic [1:0] OP_INVERSE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FLAT  = 2'd2;

    typedef struct packed {
        logic [1:0]                    operation;
        logic [IDX_WIDTH-1:0]          point_index;
        logic signed [VALUE_WIDTH-1:0] point_x;
        logic signed [VALUE_WIDTH-1:0] point_y;
        logic signed [VALUE_WIDTH-1:0] query_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] result_value;
        logic [NP_WIDTH-1:0]           segment_index;
        logic [1:0]                    status;
    } t_out_item;

    // Request to and response from the shared add/subtract unit.
    typedef struct packed {
        logic [ALU_WIDTH-1:0] op_a;
        logic [ALU_WIDTH-1:0] op_b;
        logic                 sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_WIDTH-1:0]   sum;
        logic                   neg;
        logic                   zero;
        logic [VALUE_WIDTH-1:0] mag;
    } t_alu_rsp;

endpackage

>>> hdl/pltl_mem.sv
// Point table: x and y columns, one write port and one registered read port.
module pltl_mem import pltl_pkg::*; #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [VALUE_WIDTH-1:0] i_wr_x,
    input  logic [VALUE_WIDTH-1:0] i_wr_y,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [VALUE_WIDTH-1:0] o_rd_x,
    output logic [VALUE_WIDTH-1:0] o_rd_y
);

    logic [VALUE_WIDTH-1:0] r_x_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_y_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_x;
    logic [VALUE_WIDTH-1:0] r_rd_y;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x_mem[i_wr_addr] <= i_wr_x;
            r_y_mem[i_wr_addr] <= i_wr_y;
        end
        r_rd_x <= r_x_mem[i_rd_addr];
        r_rd_y <= r_y_mem[i_rd_addr];
    end

    assign o_rd_x = r_rd_x;
    assign o_rd_y = r_rd_y;

endmodule

>>> hdl/pltl_alu.sv
// Shared add/subtract unit with sign, zero and magnitude outputs.
module pltl_alu import pltl_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_WIDTH-1:0] sum;
    logic [ALU_WIDTH-1:0] neg_sum;

    always_comb begin
        sum     = i_req.sub ? (i_req.op_a - i_req.op_b) : (i_req.op_a + i_req.op_b);
        neg_sum = '0 - sum;
        o_rsp.sum  = sum;
        o_rsp.neg  = sum[ALU_WIDTH-1];
        o_rsp.zero = (sum == '0);
        // The magnitude is only meaningful for differences of two 32-bit values.
        o_rsp.mag  = sum[ALU_WIDTH-1] ? neg_sum[VALUE_WIDTH-1:0] : sum[VALUE_WIDTH-1:0];
    end

endmodule

>>> hdl/piecewise_linear_table_lookup_top.sv
// Top level of the piecewise-linear table lookup with forward and inverse interpolation.
//
// The block keeps a table of sorted (x, y) points in signed Q16.16 and serves one item
// at a time. A write item stores one point. A lookup item (forward x to y, or inverse
// y to x) runs a lower-bound bisection search of roughly log2(num_points) + 1 steps;
// each step issues a registered table read and then compares the key it returns. The
// interpolation quotient comes out of a restoring divider that produces one bit per
// cycle; a quotient that cannot fit saturates at once and skips the division, as do
// out-of-range queries and flat segments. A single add/subtract unit is shared by the
// search compares, the segment differences, the division steps and the final
// saturating add; one 32 by 32 multiplier forms the product of the two differences. The
// input stall is high for as long as an item is in work, but a finished result sits in
// an output register so the next item is taken while the previous result waits. Table
// entries have no reset value and must be written before a lookup reaches them; no
// clearing pass runs after reset. The register num_points (byte address 0) is clamped
// to the range 2 to TABLE_DEPTH when written and must only be written while the block
// is idle.
module piecewise_linear_table_lookup_top import pltl_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int NP_MAX   = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
    localparam int CW       = $clog2(VALUE_WIDTH);
    localparam logic [NP_WIDTH-1:0] NP_MIN_V = NP_WIDTH'(2);
    localparam logic [NP_WIDTH-1:0] NP_MAX_V = NP_WIDTH'(NP_MAX);
    localparam logic [CW-1:0] DIV_LAST = CW'(VALUE_WIDTH - 1);
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_SRCH_A,
        S_SRCH_B,
        S_SEG,
        S_LDA,
        S_LDB,
        S_DK,
        S_DQ,
        S_DV,
        S_MUL,
        S_DCHK,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    function automatic logic [ALU_WIDTH-1:0] sext2(input logic [VALUE_WIDTH-1:0] v);
        return {{2{v[VALUE_WIDTH-1]}}, v};
    endfunction

    function automatic logic [ALU_WIDTH-1:0] zext2(input logic [VALUE_WIDTH-1:0] v);
        return {2'b00, v};
    endfunction

    // ------------------------------------------------------------------------
    // Configuration register. Writes are clamped so the sequencer never sees a
    // point count outside the table.
    // ------------------------------------------------------------------------
    logic [NP_WIDTH-1:0] r_num_points;
    logic [NP_WIDTH-1:0] n_num_points;
    logic [NP_WIDTH-1:0] cfg_val;
    logic                cfg_wr;

    assign cfg_val = pwdata[NP_WIDTH-1:0];
    assign cfg_wr  = psel && penable && pwrite && !paddr[2];

    always_comb begin
        if (cfg_val < NP_MIN_V) begin
            n_num_points = NP_MIN_V;
        end else if (cfg_val > NP_MAX_V) begin
            n_num_points = NP_MAX_V;
        end else begin
            n_num_points = cfg_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NP_MIN_V;
        end else if (cfg_wr) begin
            r_num_points <= n_num_points;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_num_points);

    // ------------------------------------------------------------------------
    // Sequencer state and datapath registers.
    // ------------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_q, n_q;
    logic                   r_inv, n_inv;
    logic [NP_WIDTH-1:0]    r_lo, n_lo;
    logic [NP_WIDTH-1:0]    r_cnt, n_cnt;
    logic [NP_WIDTH-1:0]    r_idx, n_idx;
    logic [NP_WIDTH-1:0]    r_seg, n_seg;
    logic [VALUE_WIDTH-1:0] r_qa, n_qa;
    logic [VALUE_WIDTH-1:0] r_qb, n_qb;
    logic [VALUE_WIDTH-1:0] r_va, n_va;
    logic [VALUE_WIDTH-1:0] r_vb, n_vb;
    logic [VALUE_WIDTH-1:0] r_dk, n_dk;
    logic [VALUE_WIDTH-1:0] r_dq, n_dq;
    logic [VALUE_WIDTH-1:0] r_dv, n_dv;
    logic                   r_neg, n_neg;
    logic [2*VALUE_WIDTH-1:0] r_prod, n_prod;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [CW-1:0]          r_dcnt, n_dcnt;
    logic                   r_sat, n_sat;
    logic [VALUE_WIDTH-1:0] r_res, n_res;
    logic [1:0]             r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_item, n_out_item;

    logic                   in_acc;
    logic                   wr_en;
    logic                   wr_in_range;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_x;
    logic [VALUE_WIDTH-1:0] rd_y;
    logic [VALUE_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] val;
    logic [NP_WIDTH-1:0]    srch_step;
    logic [2*VALUE_WIDTH-1:0] mul_p;
    logic [2:0]             fin_top;
    t_alu_req               alu_req;
    t_alu_rsp               alu_rsp;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign wr_in_range = int'(i_in_item.point_index) < TABLE_DEPTH;

    // The searched column is x for a forward lookup and y for an inverse one.
    assign key       = r_inv ? rd_y : rd_x;
    assign val       = r_inv ? rd_x : rd_y;
    assign srch_step = r_cnt >> 1;
    assign mul_p     = r_dq * r_dv;
    assign fin_top   = alu_rsp.sum[ALU_WIDTH-1:VALUE_WIDTH-1];

    pltl_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in_item.point_index)),
        .i_wr_x    (i_in_item.point_x),
        .i_wr_y    (i_in_item.point_y),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    pltl_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_inv       = r_inv;
        n_lo        = r_lo;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_seg       = r_seg;
        n_qa        = r_qa;
        n_qb        = r_qb;
        n_va        = r_va;
        n_vb        = r_vb;
        n_dk        = r_dk;
        n_dq        = r_dq;
        n_dv        = r_dv;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dcnt      = r_dcnt;
        n_sat       = r_sat;
        n_res       = r_res;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        rd_addr     = '0;
        wr_en       = 1'b0;
        alu_req     = '0;

        // The waiting result leaves when the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Address zero is read every idle cycle, so the first key is
                // ready in the cycle after a lookup is accepted.
                if (in_acc) begin
                    n_q      = i_in_item.query_value;
                    n_inv    = (i_in_item.operation == OP_INVERSE);
                    n_res    = '0;
                    n_status = ST_OK;
                    n_seg    = '0;
                    if (i_in_item.operation == OP_FORWARD ||
                        i_in_item.operation == OP_INVERSE) begin
                        n_state = S_CHK0;
                    end else begin
                        // The unused operation code behaves as a write that stores nothing.
                        wr_en   = (i_in_item.operation == OP_WRITE) && wr_in_range;
                        n_state = S_DONE;
                    end
                end
            end
            S_CHK0: begin
                alu_req = '{op_a: sext2(r_q), op_b: sext2(key), sub: 1'b1};
                if (alu_rsp.zero) begin
                    // A query exactly at the first point uses the first segment.
                    n_seg   = NP_WIDTH'(1);
                    n_state = S_SEG;
                end else begin
                    n_lo    = '0;
                    n_cnt   = r_num_points;
                    n_state = S_SRCH_A;
                end
            end
            S_SRCH_A: begin
                if (r_cnt == '0) begin
                    n_seg   = r_lo;
                    n_state = S_SEG;
                end else begin
                    n_idx   = r_lo + srch_step;
                    rd_addr = AW'(r_lo + srch_step);
                    n_state = S_SRCH_B;
                end
            end
            S_SRCH_B: begin
                alu_req = '{op_a: sext2(key), op_b: sext2(r_q), sub: 1'b1};
                if (alu_rsp.neg) begin
                    n_lo  = r_idx + NP_WIDTH'(1);
                    n_cnt = r_cnt - srch_step - NP_WIDTH'(1);
                end else begin
                    n_cnt = srch_step;
                end
                n_state = S_SRCH_A;
            end
            S_SEG: begin
                if (r_seg == '0 || r_seg >= r_num_points) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = AW'(r_seg - NP_WIDTH'(1));
                    n_state = S_LDA;
                end
            end
            S_LDA: begin
                n_qa    = key;
                n_va    = val;
                rd_addr = AW'(r_seg);
                n_state = S_LDB;
            end
            S_LDB: begin
                n_qb    = key;
                n_vb    = val;
                n_state = S_DK;
            end
            S_DK: begin
                alu_req = '{op_a: sext2(r_qb), op_b: sext2(r_qa), sub: 1'b1};
                if (alu_rsp.zero) begin
                    n_status = ST_FLAT;
                    n_state  = S_DONE;
                end else begin
                    n_dk    = alu_rsp.mag;
                    n_neg   = alu_rsp.neg;
                    n_state = S_DQ;
                end
            end
            S_DQ: begin
                alu_req = '{op_a: sext2(r_q), op_b: sext2(r_qa), sub: 1'b1};
                n_dq    = alu_rsp.mag;
                n_neg   = r_neg ^ alu_rsp.neg;
                n_state = S_DV;
            end
            S_DV: begin
                alu_req = '{op_a: sext2(r_vb), op_b: sext2(r_va), sub: 1'b1};
                n_dv    = alu_rsp.mag;
                n_neg   = r_neg ^ alu_rsp.neg;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                // If the upper half of the product reaches the divisor, the
                // quotient needs more than one word and the result saturates.
                alu_req = '{op_a: zext2(r_prod[2*VALUE_WIDTH-1:VALUE_WIDTH]),
                            op_b: zext2(r_dk), sub: 1'b1};
                if (!alu_rsp.neg) begin
                    n_sat   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_sat   = 1'b0;
                    n_rem   = r_prod[2*VALUE_WIDTH-1:VALUE_WIDTH];
                    n_quo   = r_prod[VALUE_WIDTH-1:0];
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // One restoring step: the low product bits shift out of the
                // top of r_quo while quotient bits shift in at the bottom.
                alu_req = '{op_a: {1'b0, r_rem, r_quo[VALUE_WIDTH-1]},
                            op_b: zext2(r_dk), sub: 1'b1};
                if (alu_rsp.neg) begin
                    n_rem = {r_rem[VALUE_WIDTH-2:0], r_quo[VALUE_WIDTH-1]};
                end else begin
                    n_rem = alu_rsp.sum[VALUE_WIDTH-1:0];
                end
                n_quo  = {r_quo[VALUE_WIDTH-2:0], !alu_rsp.neg};
                n_dcnt = r_dcnt + CW'(1);
                if (r_dcnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                alu_req = '{op_a: sext2(r_va), op_b: zext2(r_quo), sub: r_neg};
                if (r_sat) begin
                    n_res = r_neg ? VAL_MIN : VAL_MAX;
                end else if (fin_top == 3'b000 || fin_top == 3'b111) begin
                    n_res = alu_rsp.sum[VALUE_WIDTH-1:0];
                end else begin
                    n_res = r_neg ? VAL_MIN : VAL_MAX;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{result_value:  r_res,
                                    segment_index: r_seg,
                                    status:        r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_inv      <= n_inv;
        r_lo       <= n_lo;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_seg      <= n_seg;
        r_qa       <= n_qa;
        r_qb       <= n_qb;
        r_va       <= n_va;
        r_vb       <= n_vb;
        r_dk       <= n_dk;
        r_dq       <= n_dq;
        r_dv       <= n_dv;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dcnt     <= n_dcnt;
        r_sat      <= n_sat;
        r_res      <= n_res;
        r_status   <= n_status;
        r_out_item <= n_out_item;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // Accepting an item moves the sequencer out of idle, which raises the input stall.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("block not busy after accepting an item");

    // The partial remainder of the divider stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dk))
        else $error("division remainder reached the divisor");

    // Error results carry a zero value.
    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> (o_out_item.result_value == '0))
        else $error("error result with nonzero value");

    // A finished item waits in its state while the output register is full and stalled.
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a waiting item");

endmodule

>>> bench/piecewise_linear_table_lookup_top_tb.sv
// Self-checking testbench for the piecewise-linear table lookup block.
`timescale 1ns / 1ps

module piecewise_linear_table_lookup_top_tb;
    import pltl_pkg::*;

    // The register map holds a single register: the number of points in use.
    localparam logic [2:0] REG_NUM_POINTS = 3'd0;
    // Operation code 3 is not defined; the block must treat it as a write that does nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int    DEPTH        = 1024;
    localparam int    ITEM_TARGET  = 1650;
    // This margin is long enough to cover a lookup over a full table.
    localparam int    DRAIN_CYCLES = 100;
    localparam longint VAL_MAX     = 64'sd2147483647;
    localparam longint VAL_MIN     = -64'sd2147483648;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // Every input of the block starts at a known value before the first clock edge.
    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    // The bench's own image of the block: the two table columns and the point count.
    logic signed [31:0] x_points [DEPTH];
    logic signed [31:0] y_points [DEPTH];
    int                 point_count = 2;

    // Columns planned for the current table, used to aim queries at it.
    logic signed [31:0] plan_x [DEPTH];
    logic signed [31:0] plan_y [DEPTH];

    t_out_item pending_results [$];
    t_out_item oldest_result;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int items_sent     = 0;
    int writes_sent    = 0;
    int forward_sent   = 0;
    int inverse_sent   = 0;
    int settings_seen  = 0;
    int max_points     = 2;

    piecewise_linear_table_lookup_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; a correct run ends in a few milliseconds.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver stalls at random with the probability of the current idle phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Column accessors: a forward lookup searches x and interpolates y, an inverse
    // lookup does the opposite.
    function automatic logic signed [31:0] key_at(bit inverse, int idx);
        return inverse ? y_points[idx] : x_points[idx];
    endfunction

    function automatic logic signed [31:0] value_at(bit inverse, int idx);
        return inverse ? x_points[idx] : y_points[idx];
    endfunction

    // Applies one accepted item to the table image and returns the result it must give.
    function automatic t_out_item predict_response(t_in_item item);
        t_out_item          rsp;
        bit                 inverse;
        int                 lo_idx;
        int                 cnt;
        int                 half;
        int                 probe;
        int                 seg;
        logic signed [31:0] q;
        logic signed [31:0] qa;
        logic signed [31:0] qb;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [99:0] dq;
        logic signed [99:0] dv;
        logic signed [99:0] dk;
        logic signed [99:0] quot;
        logic signed [99:0] total;

        rsp = '0;
        case (item.operation)
            OP_WRITE: begin
                x_points[item.point_index] = item.point_x;
                y_points[item.point_index] = item.point_y;
            end
            OP_FORWARD, OP_INVERSE: begin
                inverse = (item.operation == OP_INVERSE);
                q = item.query_value;
                // A query equal to the first point is pinned to the first segment;
                // otherwise a lower-bound bisection picks the upper point of the segment.
                if (q == key_at(inverse, 0)) begin
                    seg = 1;
                end else begin
                    lo_idx = 0;
                    cnt = point_count;
                    while (cnt > 0) begin
                        half = cnt / 2;
                        probe = lo_idx + half;
                        if (key_at(inverse, probe) < q) begin
                            lo_idx = probe + 1;
                            cnt = cnt - half - 1;
                        end else begin
                            cnt = half;
                        end
                    end
                    seg = lo_idx;
                end
                rsp.segment_index = seg[NP_WIDTH-1:0];
                if (seg == 0 || seg >= point_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    qa = key_at(inverse, seg - 1);
                    qb = key_at(inverse, seg);
                    a  = value_at(inverse, seg - 1);
                    b  = value_at(inverse, seg);
                    if (qa == qb) begin
                        rsp.status = ST_FLAT;
                    end else begin
                        // Signed division truncates toward zero, as the block must.
                        dq = q - qa;
                        dv = b - a;
                        dk = qb - qa;
                        quot = (dq * dv) / dk;
                        total = a + quot;
                        if (total > VAL_MAX) begin
                            rsp.result_value = VAL_MAX[31:0];
                        end else if (total < VAL_MIN) begin
                            rsp.result_value = VAL_MIN[31:0];
                        end else begin
                            rsp.result_value = total[31:0];
                        end
                        rsp.status = ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // The checker: every result taken from the block is matched to the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("Result with no item waiting: value %0d, segment %0d, status %0d",
                       o_out_item.result_value, o_out_item.segment_index, o_out_item.status);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_out_item.result_value !== oldest_result.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           oldest_result.result_value, o_out_item.result_value);
                    error_count++;
                end
                if (o_out_item.segment_index !== oldest_result.segment_index) begin
                    $error("segment_index: expected %0d, got %0d",
                           oldest_result.segment_index, o_out_item.segment_index);
                    error_count++;
                end
                if (o_out_item.status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_result.status, o_out_item.status);
                    error_count++;
                end
            end
        end
    end

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 63; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 63; end
            default:       begin src_idle_pct = 33; sink_stall_pct = 33; end
        endcase
    endtask

    // Offers one item and holds it until the block accepts it. Valid stays high after
    // acceptance so that back-to-back items need no second assignment in one time step.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.insert(pending_results.size(), predict_response(item));
        items_sent++;
        case (item.operation)
            OP_FORWARD: forward_sent++;
            OP_INVERSE: inverse_sent++;
            default:    writes_sent++;
        endcase
    endtask

    // Lowers valid and waits until every predicted result has come back, which leaves
    // the block idle and ready for a register write.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic t_in_item make_write(input int idx, input logic signed [31:0] px,
                                            input logic signed [31:0] py);
        t_in_item item;
        item.operation   = OP_WRITE;
        item.point_index = idx[IDX_WIDTH-1:0];
        item.point_x     = px;
        item.point_y     = py;
        item.query_value = $urandom;
        return item;
    endfunction

    // Lookup items carry random bits in the fields that a lookup does not use.
    function automatic t_in_item make_lookup(input logic [1:0] op,
                                             input logic signed [31:0] q);
        t_in_item item;
        item.operation   = op;
        item.point_index = IDX_WIDTH'($urandom_range(DEPTH - 1));
        item.point_x     = $urandom;
        item.point_y     = $urandom;
        item.query_value = q;
        return item;
    endfunction

    // One APB transfer: a setup cycle, then the access cycle held until pready.
    task automatic apb_access(input bit is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= REG_NUM_POINTS;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_point_count();
        logic [31:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== 32'(point_count)) begin
            $error("num_points: expected %0d, got %0d", point_count, rdata);
            error_count++;
        end
    endtask

    // Writes the point count and reads it back. The block keeps only the low eleven
    // bits and clamps them to the range 2 to DEPTH. Call only while the block is idle.
    task automatic set_point_count(input logic [31:0] value);
        logic [31:0] rdata;
        int          clamped;
        apb_access(1'b1, value, rdata);
        clamped = int'(value[NP_WIDTH-1:0]);
        if (clamped < 2) clamped = 2;
        if (clamped > DEPTH) clamped = DEPTH;
        point_count = clamped;
        settings_seen++;
        if (clamped > max_points) max_points = clamped;
        check_point_count();
    endtask

    // Plans one column of a table: either a nondecreasing ramp with random steps (some
    // of them zero, which makes flat segments) or plain random values.
    function automatic void plan_column(input bit is_y, input int np, input bit sorted);
        longint             base;
        longint             cap;
        longint             cur;
        longint             inc;
        logic signed [31:0] v;
        if ($urandom_range(3) == 0) base = VAL_MIN + $urandom_range(1000);
        else base = longint'($signed($urandom));
        cap = (VAL_MAX - base) / (np - 1);
        if ($urandom_range(3) == 0 && cap > 64) cap = 64;
        cur = base;
        for (int i = 0; i < np; i++) begin
            v = sorted ? cur[31:0] : $urandom;
            if (is_y) plan_y[i] = v;
            else plan_x[i] = v;
            inc = ($urandom_range(9) == 0) ? 0 : longint'({32'd0, $urandom} % (cap + 1));
            cur = cur + inc;
        end
    endfunction

    // The reset value of the point count is two. A two-point table with equal y values
    // gives out-of-range queries on both sides, an exact hit on the first point and a
    // flat segment for inverse lookups.
    task automatic test_reset_table();
        set_idle_mode(IDLE_NONE);
        check_point_count();
        send_item(make_write(0, -32'sh10000, 32'sh50000));
        send_item(make_write(1, 32'sh10000, 32'sh50000));
        send_item(make_lookup(OP_FORWARD, -32'sh10000));
        send_item(make_lookup(OP_FORWARD, 32'sh0));
        send_item(make_lookup(OP_FORWARD, 32'sh10000));
        send_item(make_lookup(OP_FORWARD, -32'sh20000));
        send_item(make_lookup(OP_FORWARD, 32'sh20000));
        send_item(make_lookup(OP_INVERSE, 32'sh50000));
        send_item(make_lookup(OP_INVERSE, 32'sh0));
        send_item(make_lookup(OP_INVERSE, 32'sh60000));
        send_item(make_lookup(OP_UNUSED, 32'sh0));
    endtask

    // A three-point table that spans the full signed range in both columns, queried at
    // its ends and around zero. The point count is written with bits above the register
    // width set, which the block must drop. The last table entry is written too.
    task automatic test_extreme_values();
        set_idle_mode(IDLE_BOTH);
        wait_drained();
        set_point_count(32'h0000_0803);
        send_item(make_write(0, VAL_MIN[31:0], VAL_MIN[31:0]));
        send_item(make_write(1, 32'sh0, 32'sh10000));
        send_item(make_write(2, VAL_MAX[31:0], VAL_MAX[31:0]));
        send_item(make_write(DEPTH - 1, VAL_MAX[31:0], VAL_MIN[31:0]));
        send_item(make_lookup(OP_FORWARD, VAL_MIN[31:0]));
        send_item(make_lookup(OP_FORWARD, VAL_MAX[31:0]));
        send_item(make_lookup(OP_FORWARD, -32'sd1));
        send_item(make_lookup(OP_FORWARD, 32'sd1));
        send_item(make_lookup(OP_FORWARD, 32'sd0));
        send_item(make_lookup(OP_INVERSE, VAL_MIN[31:0]));
        send_item(make_lookup(OP_INVERSE, VAL_MAX[31:0]));
        send_item(make_lookup(OP_INVERSE, 32'sh8000));
        send_item(make_lookup(OP_INVERSE, -32'sd7));
    endtask

    // Register writes only: values below two and above the depth must clamp.
    task automatic test_point_count_clamp();
        wait_drained();
        set_point_count(32'd0);
        set_point_count(32'd1);
        set_point_count(32'd2047);
        set_point_count(32'd1025);
        set_point_count(32'd1024);
        set_point_count(32'd2);
    endtask

    // Random tables, mostly sorted as a CDF would be, each written in full before it is
    // queried. Queries aim inside the table, at exact points, just past either end, or
    // anywhere. Stray writes, writes that break the order and undefined operations are
    // mixed in. One pass uses the full table depth.
    task automatic test_random_tables();
        int                 pass_no;
        int                 np;
        int                 cfg;
        int                 n_queries;
        int                 pick;
        bit                 sorted;
        bit                 inverse;
        logic [1:0]         op;
        longint             lo_key;
        longint             hi_key;
        longint             qv;
        logic signed [31:0] q;

        pass_no = 0;
        while (items_sent < ITEM_TARGET) begin
            set_idle_mode(t_idle_mode'(pass_no % 4));
            if (pass_no == 2) np = DEPTH;
            else if (pass_no % 5 == 4) np = $urandom_range(64, 17);
            else np = $urandom_range(16, 2);
            cfg = np;
            if (np == DEPTH) cfg = 2047;
            else if (np == 2 && $urandom_range(1) == 1) cfg = $urandom_range(1);
            wait_drained();
            set_point_count(32'(cfg));

            sorted = ($urandom_range(5) != 0);
            plan_column(1'b0, np, sorted);
            plan_column(1'b1, np, sorted);
            for (int i = 0; i < np; i++) begin
                send_item(make_write(i, plan_x[i], plan_y[i]));
            end

            n_queries = (np == DEPTH) ? 60 : 24 + $urandom_range(16);
            for (int j = 0; j < n_queries; j++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    // A write beyond the points in use must not disturb the lookups; a full table takes it anywhere.
                    send_item(make_write((np < DEPTH) ? $urandom_range(DEPTH - 1, np)
                                                      : $urandom_range(DEPTH - 1),
                                         $urandom, $urandom));
                end else if (pick < 12) begin
                    send_item(make_write($urandom_range(np - 1), $urandom, $urandom));
                end else if (pick < 16) begin
                    send_item(make_lookup(OP_UNUSED, $urandom));
                end else begin
                    inverse = 1'($urandom_range(1));
                    op = inverse ? OP_INVERSE : OP_FORWARD;
                    lo_key = inverse ? plan_y[0] : plan_x[0];
                    hi_key = inverse ? plan_y[np - 1] : plan_x[np - 1];
                    pick = $urandom_range(99);
                    if (pick < 55 && hi_key >= lo_key) begin
                        qv = lo_key + longint'({32'd0, $urandom} % (hi_key - lo_key + 1));
                    end else if (pick < 75) begin
                        pick = $urandom_range(np - 1);
                        qv = inverse ? plan_y[pick] : plan_x[pick];
                    end else if (pick < 85) begin
                        qv = $urandom_range(1) ? lo_key - 1 : hi_key + 1;
                    end else begin
                        qv = longint'($signed($urandom));
                    end
                    if (qv < VAL_MIN || qv > VAL_MAX) qv = longint'($signed($urandom));
                    q = qv[31:0];
                    send_item(make_lookup(op, q));
                end
            end
            pass_no++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_table();
        test_extreme_values();
        test_point_count_clamp();
        test_random_tables();

        // Let the last results drain, then give the block time to show any extra result.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d writes, %0d forward and %0d inverse lookups.",
                 items_sent, writes_sent, forward_sent, inverse_sent);
        $display("The point count took %0d settings, with tables of up to %0d points.",
                 settings_seen, max_points);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
